@@ hw/rtl/spcl_pkg.sv @@
// Shared constants and codes for the smooth palette colour lookup.
package spcl_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int FRACTION_BITS = 8;

    // Fixed field widths
    localparam int ITER_W     = 32;
    localparam int MAXIT_W    = 24;
    localparam int PSIZE_W    = 9;
    localparam int CHAN_W     = 8;
    localparam int ENTRY_W    = 8;
    localparam int COLOUR_W   = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER     = 3'd0,
        CFG_PALETTE_SIZE = 3'd1,
        CFG_INSIDE_RED   = 3'd2,
        CFG_INSIDE_GREEN = 3'd3,
        CFG_INSIDE_BLUE  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_WRITE  = 1'b1
    } cmd_t;

endpackage

@@ hw/rtl/spcl_if.sv @@
// Request, result and configuration channel interfaces.
interface spcl_pix_in_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic [spcl_pkg::ITER_W-1:0]        iter_fixed;
    logic [spcl_pkg::ENTRY_W-1:0]       entry_index;
    logic [spcl_pkg::CHAN_W-1:0]        entry_red;
    logic [spcl_pkg::CHAN_W-1:0]        entry_green;
    logic [spcl_pkg::CHAN_W-1:0]        entry_blue;

    modport source (output valid, cmd, iter_fixed, entry_index, entry_red, entry_green,
                    entry_blue, input ready);
    modport sink   (input valid, cmd, iter_fixed, entry_index, entry_red, entry_green,
                    entry_blue, output ready);
endinterface

interface spcl_pix_out_if;
    logic                               valid;
    logic                               ready;
    logic [spcl_pkg::CHAN_W-1:0]        red;
    logic [spcl_pkg::CHAN_W-1:0]        green;
    logic [spcl_pkg::CHAN_W-1:0]        blue;
    logic                               inside_res;

    modport source (output valid, red, green, blue, inside_res, input ready);
    modport sink   (input valid, red, green, blue, inside_res, output ready);
endinterface

interface spcl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [spcl_pkg::CFG_IDX_W-1:0]     index;
    logic [spcl_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/smooth_palette_color_lookup.sv @@
// Smooth palette colour lookup: pipelined escape-count to pixel colour.
// A lookup passes the entry stage, remainder stages, palette read and output register.
// Throughput: one request per cycle if not stalled; depth is set by the remainder unit
// (8 quotient bits per stage), the registered palette read and the output register.
// Reset: rst_n clears all valid bits and loads the register defaults at once.
// The palette store has no reset; entries are undefined until written.
module smooth_palette_color_lookup (
    input  logic               clk,
    input  logic               rst_n,
    spcl_pix_in_if.sink        pix_in,
    spcl_pix_out_if.source     pix_out,
    spcl_cfg_if.sink           cfg
);

    localparam int DEPTH   = spcl_pkg::PALETTE_DEPTH;
    localparam int FB      = spcl_pkg::FRACTION_BITS;
    localparam int CW      = spcl_pkg::CHAN_W;
    localparam int COL_W   = spcl_pkg::COLOUR_W;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int SIZE_W  = $clog2(DEPTH + 1);
    localparam int INT_W   = spcl_pkg::ITER_W - FB;
    // Remainder unit: STEP quotient bits resolved per stage, RS stages
    localparam int STEP    = 8;
    localparam int RS      = (INT_W + STEP - 1) / STEP;
    localparam int DIV_W   = RS * STEP;
    localparam int LIM_W   = spcl_pkg::MAXIT_W + FB;
    localparam int CMP_W   = (LIM_W > spcl_pkg::ITER_W) ? LIM_W : spcl_pkg::ITER_W;
    localparam int ACC_W   = CW + FB + 2;

    // Per-stage record for the front end and the remainder stages
    typedef struct packed {
        logic                            cmd;
        logic                            at_limit;
        logic [FB-1:0]                   frac;
        logic [DIV_W-1:0]                dvd;
        logic [SIZE_W-1:0]               rem;
        logic [spcl_pkg::ENTRY_W-1:0]    idx;
        logic [COL_W-1:0]                colour;
    } stg_t;

    // Restoring remainder, STEP dividend bits
    function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] r_in,
                                                   input logic [STEP-1:0]   bits,
                                                   input logic [SIZE_W-1:0] modulus);
        logic [SIZE_W:0]   t;
        logic [SIZE_W-1:0] r;
        r = r_in;
        for (int i = STEP - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, modulus})
            begin
                t = t - {1'b0, modulus};
            end
            r = t[SIZE_W-1:0];
        end
        return r;
    endfunction

    // a + f*(b-a)/2^FB, floored; equals ((2^FB-f)*a + f*b) >> FB
    function automatic logic [CW-1:0] blend(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b,
                                            input logic [FB-1:0] f);
        logic signed [CW:0]      diff;
        logic signed [ACC_W-1:0] acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        acc  = $signed({2'b00, a, {FB{1'b0}}}) +
               ACC_W'(diff) * ACC_W'($signed({1'b0, f}));
        return acc[CW+FB-1:FB];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [spcl_pkg::MAXIT_W-1:0] iter_limit_reg;
    logic [spcl_pkg::PSIZE_W-1:0] psize_reg;
    logic [CW-1:0]                in_red_reg;
    logic [CW-1:0]                in_green_reg;
    logic [CW-1:0]                in_blue_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_limit_reg <= spcl_pkg::MAXIT_W'(256);
            psize_reg      <= spcl_pkg::PSIZE_W'(256);
            in_red_reg     <= '0;
            in_green_reg   <= '0;
            in_blue_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                spcl_pkg::CFG_MAX_ITER:     iter_limit_reg <= cfg.data[spcl_pkg::MAXIT_W-1:0];
                spcl_pkg::CFG_PALETTE_SIZE: psize_reg      <= cfg.data[spcl_pkg::PSIZE_W-1:0];
                spcl_pkg::CFG_INSIDE_RED:   in_red_reg     <= cfg.data[CW-1:0];
                spcl_pkg::CFG_INSIDE_GREEN: in_green_reg   <= cfg.data[CW-1:0];
                spcl_pkg::CFG_INSIDE_BLUE:  in_blue_reg    <= cfg.data[CW-1:0];
                default:                    ;
            endcase
        end
    end

    // Effective modulus: zero reads as one, oversize clamps to the store depth
    logic [SIZE_W-1:0]  size_eff;
    logic [CMP_W-1:0]   limit;

    always_comb
    begin
        if (psize_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (int'(psize_reg) > DEPTH)
        begin
            size_eff = SIZE_W'(DEPTH);
        end
        else
        begin
            size_eff = SIZE_W'(psize_reg);
        end
        limit = CMP_W'({iter_limit_reg, {FB{1'b0}}});
    end

    // ---------------------------------------------------------------
    // Handshake: each stage loads when empty or when its successor loads
    // ---------------------------------------------------------------
    stg_t          pipe_reg  [0:RS];
    stg_t          pipe_next [0:RS];
    logic [RS:0]   valid_reg;
    logic [RS:0]   rdy;
    logic          rd_valid_reg;
    logic          rd_rdy;
    logic          out_valid_reg;
    logic          out_rdy;

    assign out_rdy = !out_valid_reg || pix_out.ready;
    assign rd_rdy  = !rd_valid_reg || out_rdy;

    always_comb
    begin
        rdy[RS] = !valid_reg[RS] || rd_rdy;
        for (int k = RS - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign pix_in.ready = rdy[0];

    // ---------------------------------------------------------------
    // Stage 0: limit compare and capture; stages 1..RS: remainder
    // ---------------------------------------------------------------
    always_comb
    begin
        pipe_next[0].cmd      = pix_in.cmd;
        pipe_next[0].at_limit = CMP_W'(pix_in.iter_fixed) >= limit;
        pipe_next[0].frac     = pix_in.iter_fixed[FB-1:0];
        pipe_next[0].dvd      = DIV_W'(pix_in.iter_fixed[spcl_pkg::ITER_W-1:FB]);
        pipe_next[0].rem      = '0;
        pipe_next[0].idx      = pix_in.entry_index;
        pipe_next[0].colour   = {pix_in.entry_red, pix_in.entry_green, pix_in.entry_blue};
        for (int k = 1; k <= RS; k++)
        begin
            pipe_next[k]     = pipe_reg[k-1];
            pipe_next[k].rem = rem_step(pipe_reg[k-1].rem,
                                        pipe_reg[k-1].dvd[DIV_W-1 -: STEP], size_eff);
            pipe_next[k].dvd = pipe_reg[k-1].dvd << STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= pix_in.valid;
            end
            for (int k = 1; k <= RS; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= RS; k++)
        begin
            if (rdy[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Palette stage: writes retire here in order, lookups read i and i+1
    // ---------------------------------------------------------------
    logic [COL_W-1:0]   palette_mem [0:DEPTH-1];
    logic [SIZE_W-1:0]  nxt_idx;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    logic               tail_write;
    logic [COL_W-1:0]   c1_reg;
    logic [COL_W-1:0]   c2_reg;
    logic               rd_inside_reg;
    logic [FB-1:0]      rd_frac_reg;

    assign tail_write = pipe_reg[RS].cmd == spcl_pkg::CMD_WRITE;
    assign nxt_idx    = pipe_reg[RS].rem + SIZE_W'(1);
    assign rd_addr_a  = pipe_reg[RS].rem[IDX_W-1:0];
    assign rd_addr_b  = (nxt_idx == size_eff) ? '0 : nxt_idx[IDX_W-1:0];
    assign wr_addr    = IDX_W'(pipe_reg[RS].idx);
    assign wr_en      = rd_rdy && valid_reg[RS] && tail_write &&
                        (int'(pipe_reg[RS].idx) < DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[wr_addr] <= pipe_reg[RS].colour;
        end
        if (rd_rdy)
        begin
            c1_reg        <= palette_mem[rd_addr_a];
            c2_reg        <= palette_mem[rd_addr_b];
            rd_inside_reg <= pipe_reg[RS].at_limit;
            rd_frac_reg   <= pipe_reg[RS].frac;
        end
    end

    // Write requests end here and give no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (rd_rdy)
        begin
            rd_valid_reg <= valid_reg[RS] && !tail_write;
        end
    end

    // ---------------------------------------------------------------
    // Blend or inside colour select, and output register
    // ---------------------------------------------------------------
    logic [CW-1:0] red_reg,   red_next;
    logic [CW-1:0] green_reg, green_next;
    logic [CW-1:0] blue_reg,  blue_next;
    logic          inside_reg;

    always_comb
    begin
        if (rd_inside_reg)
        begin
            red_next   = in_red_reg;
            green_next = in_green_reg;
            blue_next  = in_blue_reg;
        end
        else
        begin
            red_next   = blend(c1_reg[3*CW-1:2*CW], c2_reg[3*CW-1:2*CW], rd_frac_reg);
            green_next = blend(c1_reg[2*CW-1:CW],   c2_reg[2*CW-1:CW],   rd_frac_reg);
            blue_next  = blend(c1_reg[CW-1:0],      c2_reg[CW-1:0],      rd_frac_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            inside_reg <= rd_inside_reg;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.red        = red_reg;
    assign pix_out.green      = green_reg;
    assign pix_out.blue       = blue_reg;
    assign pix_out.inside_res = inside_reg;

`ifndef NO_ASSERTIONS
    // Remainder leaving the divider is a valid palette index
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[RS] |-> (pipe_reg[RS].rem < size_eff))
        else $error("remainder not below palette size");

    // A palette write retires without a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_rdy && valid_reg[RS] && tail_write) |=> !rd_valid_reg)
        else $error("write request produced a result");

    // An accepted request occupies the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) |=> valid_reg[0])
        else $error("accepted request lost at entry");

    // An empty pipeline always takes a request
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0 && !rd_valid_reg && !out_valid_reg) |-> pix_in.ready)
        else $error("empty pipeline not ready");
`endif

endmodule
